[src/ssf_pkg.sv]
package ssf_pkg;

    // field widths
    localparam int VAL_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int THR_W      = 10;
    localparam int QC_W       = 6;
    localparam int CL_W       = 7;
    localparam int PUMP_OUT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALIFY_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH    = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET = 10'd770;
    localparam logic [QC_W-1:0]  QC_RESET  = 6'd5;
    localparam logic [CL_W-1:0]  CL_RESET  = 7'd68;

    // frame marker and escaped byte value
    localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_SUBST  = 8'h00;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [BYTE_W-1:0] t_byte;

    // status of the frame queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

[src/ssf_front.sv]
module ssf_front #(
    parameter int NUM_SOIL = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ssf_pkg::t_val                 i_sample,
    output logic                          o_full,
    input  logic                          i_cfg_we,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  ssf_pkg::t_q_flags             i_q_flags,
    output logic                          o_q_push,
    output logic [ssf_pkg::PUMP_OUT_W+ssf_pkg::VAL_W*(NUM_SOIL+1)-1:0] o_q_data
);
    import ssf_pkg::*;

    localparam int NUM_VALUES = NUM_SOIL + 1;
    localparam int SLOT_W     = $clog2(NUM_VALUES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SOIL);

    logic [THR_W-1:0]    r_thr;
    logic [QC_W-1:0]     r_qc;
    logic [CL_W-1:0]     r_cl;
    logic [SLOT_W-1:0]   r_slot;
    t_val                r_held [NUM_SOIL];
    logic [CL_W-1:0]     r_cnt  [NUM_SOIL];
    logic [CL_W-1:0]     n_cnt  [NUM_SOIL];
    logic [NUM_SOIL-1:0] r_pump;
    logic [NUM_SOIL-1:0] n_pump;
    t_val                w_vals [NUM_VALUES];
    logic                w_accept;
    logic                w_frame;
    logic [CL_W-1:0]     w_qc_ext;
    logic [NUM_SOIL+PUMP_OUT_W-1:0] w_pump_pad;

    // classify the incoming transaction
    assign o_full   = (r_slot == LAST_SLOT) && i_q_flags.full;
    assign w_accept = i_push && !o_full;
    assign w_frame  = w_accept && (r_slot == LAST_SLOT);
    assign o_q_push = w_frame;
    assign w_qc_ext = CL_W'(r_qc);

    // values of the frame, the last soil reading straight from the input
    always_comb begin
        for (int i = 0; i < NUM_SOIL; i++) begin
            w_vals[i] = r_held[i];
        end
        w_vals[NUM_SOIL] = i_sample;
    end

    // pump timers, one lane per soil channel
    always_comb begin
        n_pump = r_pump;
        for (int c = 0; c < NUM_SOIL; c++) begin
            n_cnt[c] = r_cnt[c];
            if (w_frame) begin
                if (w_vals[c+1] > r_thr || r_cnt[c] >= w_qc_ext) begin
                    if (r_cnt[c] == w_qc_ext) begin
                        n_pump[c] = 1'b1;
                        n_cnt[c]  = r_cnt[c] + 7'd1;
                    end else if (r_cnt[c] >= r_cl) begin
                        n_pump[c] = 1'b0;
                        n_cnt[c]  = 7'd1;
                    end else begin
                        n_pump[c] = 1'b0;
                        n_cnt[c]  = r_cnt[c] + 7'd1;
                    end
                end else begin
                    n_pump[c] = 1'b0;
                    n_cnt[c]  = '0;
                end
            end
        end
    end

    // frame entry for the queue
    assign w_pump_pad = {{PUMP_OUT_W{1'b0}}, n_pump};
    always_comb begin
        o_q_data[PUMP_OUT_W+VAL_W*NUM_VALUES-1 -: PUMP_OUT_W] = w_pump_pad[PUMP_OUT_W-1:0];
        for (int i = 0; i < NUM_VALUES; i++) begin
            o_q_data[i*VAL_W +: VAL_W] = w_vals[i];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_qc  <= QC_RESET;
            r_cl  <= CL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WATER_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_QUALIFY_COUNT:   r_qc  <= i_cfg_data[QC_W-1:0];
                CFG_CYCLE_LENGTH:    r_cl  <= i_cfg_data[CL_W-1:0];
                default: ;
            endcase
        end
    end

    // channel rotation, held values and pump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pump <= '0;
            for (int i = 0; i < NUM_SOIL; i++) begin
                r_held[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (w_accept) begin
                if (r_slot == LAST_SLOT) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
                for (int i = 0; i < NUM_SOIL; i++) begin
                    if (r_slot == SLOT_W'(i)) begin
                        r_held[i] <= i_sample;
                    end
                end
            end
            r_pump <= n_pump;
            for (int i = 0; i < NUM_SOIL; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

endmodule

[src/ssf_fifo.sv]
module ssf_fifo #(
    parameter int W = 54
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [W-1:0]      i_data,
    input  logic              i_pop,
    output logic [W-1:0]      o_data,
    output ssf_pkg::t_q_flags o_flags
);
    import ssf_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         w_wr;
    logic         w_rd;

    // two-entry frame queue
    assign o_flags.full  = (r_count == 2'd2);
    assign o_flags.empty = (r_count == 2'd0);
    assign w_wr   = i_push && !o_flags.full;
    assign w_rd   = i_pop && !o_flags.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[src/ssf_back.sv]
module ssf_back #(
    parameter int NUM_SOIL = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssf_pkg::t_q_flags               i_q_flags,
    input  logic [ssf_pkg::PUMP_OUT_W+ssf_pkg::VAL_W*(NUM_SOIL+1)-1:0] i_q_data,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  logic                            i_pop,
    output ssf_pkg::t_byte                  o_frame_byte,
    output logic                            o_last,
    output logic [ssf_pkg::PUMP_OUT_W-1:0]  o_pump_on
);
    import ssf_pkg::*;

    localparam int NUM_VALUES = NUM_SOIL + 1;
    localparam int ESC_W      = 2 * NUM_VALUES;
    localparam int FRAME_LEN  = 2 * NUM_VALUES + 3;
    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int VIDX_W     = $clog2(NUM_VALUES);
    localparam logic [CNT_W-1:0] IDX_LAST     = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] IDX_ESC_HI   = CNT_W'(FRAME_LEN - 2);
    localparam logic [CNT_W-1:0] IDX_DATA_END = CNT_W'(2 * NUM_VALUES);

    logic [CNT_W-1:0]      r_idx;
    logic                  r_out_valid;
    t_byte                 r_out_byte;
    logic                  r_out_last;
    logic [PUMP_OUT_W-1:0] r_out_pump;
    t_byte                 w_hi [NUM_VALUES];
    t_byte                 w_lo [NUM_VALUES];
    logic [ESC_W-1:0]      w_esc_full;
    logic [ESC_W+15:0]     w_esc_pad;
    logic [15:0]           w_esc;
    logic [CNT_W-1:0]      w_j;
    logic [VIDX_W-1:0]     w_vidx;
    t_byte                 w_byte;
    logic                  w_adv;
    t_val                  w_v;

    // split values into bytes and collect escape flags
    always_comb begin
        w_esc_full = '0;
        for (int i = 0; i < NUM_VALUES; i++) begin
            w_v     = i_q_data[i*VAL_W +: VAL_W];
            w_hi[i] = BYTE_W'(w_v >> BYTE_W);
            w_lo[i] = w_v[BYTE_W-1:0];
            if (w_hi[i] == ESC_BYTE) begin
                w_hi[i] = ESC_SUBST;
                w_esc_full[ESC_W-1-2*i] = 1'b1;
            end
            if (w_lo[i] == ESC_BYTE) begin
                w_lo[i] = ESC_SUBST;
                w_esc_full[ESC_W-2-2*i] = 1'b1;
            end
        end
    end

    // escape word as sent, upper bits dropped
    assign w_esc_pad = {16'b0, w_esc_full};
    assign w_esc     = w_esc_pad[15:0];

    // byte selection by position in the frame
    assign w_j    = r_idx - 1'b1;
    assign w_vidx = w_j[VIDX_W:1];
    always_comb begin
        if (r_idx == '0) begin
            w_byte = START_BYTE;
        end else if (r_idx <= IDX_DATA_END) begin
            w_byte = w_j[0] ? w_lo[w_vidx] : w_hi[w_vidx];
        end else if (r_idx == IDX_ESC_HI) begin
            w_byte = w_esc[15:8];
        end else begin
            w_byte = w_esc[7:0];
        end
    end

    // advance when a frame is queued and the output register is free or being taken
    assign w_adv   = !i_q_flags.empty && (!r_out_valid || i_pop);
    assign o_q_pop = w_adv && (r_idx == IDX_LAST);

    assign o_empty      = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;
    assign o_pump_on    = r_out_pump;

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_idx == IDX_LAST);
            r_out_pump <= i_q_data[PUMP_OUT_W+VAL_W*NUM_VALUES-1 -: PUMP_OUT_W];
        end
    end

    // byte counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                if (r_idx == IDX_LAST) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[src/sensor_scan_framer_pump_ctrl_core.sv]
// with the byte output idle, a frame enters the queue at the edge that accepts the last
// soil sample of a rotation, and its first byte then reaches the outputs through the
// output register
// throughput: one sample per cycle in while full is low, one frame byte per cycle out
// while pop is high; a frame of 2*NUM_SOIL+5 bytes per NUM_SOIL+1 samples sets the
// sustained rate, limited by the single byte output register
// reset: synchronous active-low clears rotation, held values, pump timers, queue, output
module sensor_scan_framer_pump_ctrl_core #(
    parameter int NUM_SOIL = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  ssf_pkg::t_val                  i_sample,
    output logic                           empty,
    input  logic                           pop,
    output ssf_pkg::t_byte                 o_frame_byte,
    output logic                           o_last,
    output logic [ssf_pkg::PUMP_OUT_W-1:0]  o_pump_on,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ssf_pkg::*;

    localparam int Q_W = PUMP_OUT_W + VAL_W * (NUM_SOIL + 1);

    t_q_flags       w_q_flags;
    logic           w_q_push;
    logic           w_q_pop;
    logic [Q_W-1:0] w_q_wdata;
    logic [Q_W-1:0] w_q_rdata;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // sample intake, pump timers and frame capture
    ssf_front #(
        .NUM_SOIL (NUM_SOIL)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_sample    (i_sample),
        .o_full      (full),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_flags   (w_q_flags),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    // frame queue between intake and byte output
    ssf_fifo #(
        .W (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_flags (w_q_flags)
    );

    // frame serializer
    ssf_back #(
        .NUM_SOIL (NUM_SOIL)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_flags    (w_q_flags),
        .i_q_data     (w_q_rdata),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last),
        .o_pump_on    (o_pump_on)
    );

endmodule

[sim/tb_sensor_scan_framer_pump_ctrl_core.sv]
module tb_sensor_scan_framer_pump_ctrl_core;
    import ssf_pkg::*;

    localparam int NUM_SOIL      = 4;
    localparam int NUM_CH        = NUM_SOIL + 1;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // one expected frame byte with its side fields
    typedef struct packed {
        t_byte                 data;
        logic                  last;
        logic [PUMP_OUT_W-1:0] pumps;
    } t_frame_entry;

    // predictor of frame bytes and pump timers, plus the queue of pending bytes
    class pump_frame_scoreboard;
        logic [THR_W-1:0]    threshold;
        logic [QC_W-1:0]     qualify;
        logic [CL_W-1:0]     wrap_at;
        int unsigned         slot;
        t_val                held [NUM_CH];
        logic [CL_W-1:0]     dry_count [NUM_SOIL];
        logic [NUM_SOIL-1:0] pumps;
        t_frame_entry        expected_bytes [$];
        int                  errors;

        function new();
            threshold = THR_RESET;
            qualify   = QC_RESET;
            wrap_at   = CL_RESET;
            slot      = 0;
            pumps     = '0;
            errors    = 0;
            foreach (held[i]) held[i] = '0;
            foreach (dry_count[i]) dry_count[i] = '0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // register write, value masked to the register width
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WATER_THRESHOLD: threshold = data[THR_W-1:0];
                CFG_QUALIFY_COUNT:   qualify   = data[QC_W-1:0];
                CFG_CYCLE_LENGTH:    wrap_at   = data[CL_W-1:0];
                default: ;
            endcase
        endfunction

        // pump timer of one soil channel, run on the raw reading
        function void step_timer(int ch);
            logic [CL_W-1:0] c;
            c = dry_count[ch];
            if (held[ch + 1] > threshold || c >= qualify) begin
                if (c == qualify) begin
                    pumps[ch] = 1'b1;
                    c = c + 1'b1;
                end else if (c >= wrap_at) begin
                    pumps[ch] = 1'b0;
                    c = 1;
                end else begin
                    pumps[ch] = 1'b0;
                    c = c + 1'b1;
                end
            end else begin
                pumps[ch] = 1'b0;
                c = '0;
            end
            dry_count[ch] = c;
        endfunction

        function void add_byte(t_byte b, logic l);
            t_frame_entry e;
            e.data  = b;
            e.last  = l;
            e.pumps = pumps[PUMP_OUT_W-1:0];
            expected_bytes.push_back(e);
        endfunction

        // accepted sample: hold it, and build the frame at the end of a rotation
        function void note_sample(t_val v);
            t_byte      hi_b [NUM_CH];
            t_byte      lo_b [NUM_CH];
            logic [9:0] esc;
            int         bitpos;
            held[slot] = v;
            if (slot + 1 < NUM_CH) begin
                slot++;
                return;
            end
            slot = 0;
            for (int ch = 0; ch < NUM_SOIL; ch++) step_timer(ch);
            esc    = '0;
            bitpos = 2 * NUM_SOIL + 1;
            for (int i = 0; i < NUM_CH; i++) begin
                hi_b[i] = t_byte'(held[i] >> 8);
                lo_b[i] = held[i][7:0];
                if (hi_b[i] == ESC_BYTE) begin
                    hi_b[i] = ESC_SUBST;
                    esc[bitpos] = 1'b1;
                end
                if (lo_b[i] == ESC_BYTE) begin
                    lo_b[i] = ESC_SUBST;
                    esc[bitpos - 1] = 1'b1;
                end
                bitpos -= 2;
            end
            add_byte(START_BYTE, 1'b0);
            for (int i = 0; i < NUM_CH; i++) begin
                add_byte(hi_b[i], 1'b0);
                add_byte(lo_b[i], 1'b0);
            end
            add_byte(t_byte'(esc >> 8), 1'b0);
            add_byte(esc[7:0], 1'b1);
        endfunction

        // compare one accepted frame byte with the oldest pending one
        function void check_byte(t_byte b, logic l, logic [PUMP_OUT_W-1:0] p);
            t_frame_entry e;
            if (expected_bytes.size() == 0) begin
                $error("frame_byte %0d arrived with nothing pending", b);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.data) begin
                $error("frame_byte: expected %0d, got %0d", e.data, b);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, l);
                errors++;
            end
            if (p !== e.pumps) begin
                $error("pump_on: expected %0h, got %0h", e.pumps, p);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_val                  i_sample;
    logic                  empty;
    logic                  pop;
    t_byte                 o_frame_byte;
    logic                  o_last;
    logic [PUMP_OUT_W-1:0] o_pump_on;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pump_frame_scoreboard sb;
    int tx_streak;
    int rx_streak;
    int rx_hold_cycles;

    // directed rotations: zeros, threshold edges, escaped low bytes, all ones
    t_val directed_samples [25] = '{
        10'd0,    10'd0,    10'd0,    10'd0,    10'd0,
        10'd1023, 10'd255,  10'd511,  10'd771,  10'd770,
        10'd767,  10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd768,  10'd1023, 10'd1,    10'd1023, 10'd512,
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023
    };

    sensor_scan_framer_pump_ctrl_core #(
        .NUM_SOIL(NUM_SOIL)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last),
        .o_pump_on    (o_pump_on),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // gap length: mostly none, some short, a few long, with idle-free streaks
    function automatic int pick_gap(inout int streak);
        int r;
        if (streak > 0) begin
            streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            streak = $urandom_range(15, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sample value: escape-prone, extremes, threshold edges, or dry/wet by bias
    function automatic t_val pick_sample(bit soil, int dry_pct, logic [THR_W-1:0] thr);
        int   r;
        t_val v;
        r = $urandom_range(0, 99);
        v = t_val'($urandom_range(0, 1023));
        if (r < 12) begin
            v[BYTE_W-1:0] = ESC_BYTE;
        end else if (r < 15) begin
            v = '0;
        end else if (r < 18) begin
            v = '1;
        end else if (soil && r < 26) begin
            v = thr + t_val'(r & 1);
        end else if (soil) begin
            if ($urandom_range(0, 99) < dry_pct) begin
                if (thr != '1) v = t_val'($urandom_range(int'(thr) + 1, 1023));
            end else begin
                v = t_val'($urandom_range(0, int'(thr)));
            end
        end
        return v;
    endfunction

    // offer one sample after a random gap and wait for its transaction
    task automatic send_sample(t_val v);
        int gap;
        gap = pick_gap(tx_streak);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (full);
        sb.note_sample(v);
    endtask

    task automatic run_random(int count, int dry_pct);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(sb.slot != 0, dry_pct, sb.threshold));
    endtask

    // stop sending, let every pending frame byte drain, then settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register transaction; valid stays high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_regs(int thr, int qc, int cl);
        write_reg(CFG_WATER_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_QUALIFY_COUNT, CFG_DATA_W'(qc));
        write_reg(CFG_CYCLE_LENGTH, CFG_DATA_W'(cl));
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random pop gaps plus an optional long hold-off
    initial begin : result_side
        int gap;
        gap = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                pop <= 1'b0;
            end else if (pop && !empty) begin
                gap = pick_gap(rx_streak);
                pop <= (gap == 0);
            end else if (!pop) begin
                if (gap > 0) gap--;
                if (gap == 0) pop <= 1'b1;
            end
        end
    end

    // check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pop && empty === 1'b0)
            sb.check_byte(o_frame_byte, o_last, o_pump_on);
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial begin
        sb             = new();
        tx_streak      = 0;
        rx_streak      = 0;
        rx_hold_cycles = 0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_WATER_THRESHOLD;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rotations at reset register values
        foreach (directed_samples[k]) send_sample(directed_samples[k]);
        wait_idle();

        // short timer: pump comes on quickly and wraps
        set_regs(600, 2, 6);
        run_random(40, 70);
        wait_idle();

        // smallest consistent settings, every nonzero reading dry
        set_regs(0, 1, 2);
        run_random(30, 80);
        wait_idle();

        // inconsistent settings: zero counts, nothing dry
        set_regs(1023, 0, 0);
        run_random(20, 50);
        wait_idle();

        // largest counts through masked writes, unused index ignored
        write_reg(CFG_QUALIFY_COUNT, '1);
        write_reg(CFG_CYCLE_LENGTH, '1);
        write_reg(CFG_WATER_THRESHOLD, CFG_DATA_W'(512));
        write_reg(CFG_NO_REG, '1);
        i_cfg_valid <= 1'b0;
        run_random(20, 90);
        wait_idle();

        // random threshold; receiver holds off so the block fills and stalls
        set_regs($urandom_range(300, 900), 3, 9);
        rx_hold_cycles = 250;
        run_random(75, 75);
        wait_idle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
